// ----- rtl/oeq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the odd/even two-queue scheduler.
// No dependencies.
package oeq_pkg;

    // width of the task id fields on the request and result channels
    localparam int ID_FIELD_W = 8;

    // operation codes of a request
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    // queue select codes
    localparam logic Q_EVEN = 1'b0;
    localparam logic Q_ODD  = 1'b1;

    // request handed to the pointer unit at the accept edge
    typedef struct packed {
        logic start;     // a request is accepted this cycle
        logic op;        // OP_ADD or OP_GET
        logic requeue;   // get-next with a running task that has time left
    } t_cmd;

    // push/pop plan decided by the pointer unit
    typedef struct packed {
        logic push_en;   // write the pushed id into the memory
        logic push_q;    // queue that receives the push
        logic full;      // the push target was full, id dropped
        logic pop_en;    // read the head of a queue
        logic pop_q;     // queue that is popped
        logic fwd;       // popped entry is the one pushed this cycle
    } t_plan;

endpackage

// ----- rtl/oeq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the scheduler: request and result.
// Depends on oeq_pkg.
interface oeq_req_if
    import oeq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [ID_FIELD_W-1:0] task_id;
    logic                  running_has_time;

    modport source (output valid, op, task_id, running_has_time, input ready);
    modport sink   (input valid, op, task_id, running_has_time, output ready);
endinterface

interface oeq_rsp_if
    import oeq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ID_FIELD_W-1:0] next_task;
    logic                  next_valid;
    logic                  full_error;

    modport source (output valid, next_task, next_valid, full_error, input ready);
    modport sink   (input valid, next_task, next_valid, full_error, output ready);
endinterface

// ----- rtl/oeq_mem.sv -----
`timescale 1ns / 1ps
// Task id storage for both queues: one write port, one registered read port.
// Depends on nothing but its parameters.
module oeq_mem #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // read-first: a read of the address written in the same cycle sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/oeq_ptrs.sv -----
`timescale 1ns / 1ps
// Head pointers, fill counts and arrival parity of the two queues; decides
// the push and pop of each request. Depends on oeq_pkg.
module oeq_ptrs
    import oeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int SLOT_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_plan             o_plan,
    output logic [SLOT_W-1:0] o_push_slot,
    output logic [SLOT_W-1:0] o_pop_slot
);

    localparam int SUM_W = CNT_W + 1;

    logic [SLOT_W-1:0] r_even_head, n_even_head;
    logic [SLOT_W-1:0] r_odd_head,  n_odd_head;
    logic [CNT_W-1:0]  r_even_cnt,  n_even_cnt;
    logic [CNT_W-1:0]  r_odd_cnt,   n_odd_cnt;
    logic              r_parity,    n_parity;

    logic [SLOT_W-1:0] w_tgt_head;
    logic [CNT_W-1:0]  w_tgt_cnt;
    logic [SUM_W-1:0]  w_tail_sum;
    logic [SUM_W-1:0]  w_tail;
    logic              w_push_req;
    logic              w_push_en;
    logic              w_full;
    logic [CNT_W-1:0]  w_even_cnt_p;
    logic [CNT_W-1:0]  w_odd_cnt_p;
    logic              w_pop_en;
    logic              w_pop_q;
    logic              w_pop_even;
    logic              w_pop_odd;
    logic              w_fwd;
    logic [SLOT_W-1:0] w_pop_head;

    // push target follows the arrival parity
    always_comb begin
        w_tgt_head = (r_parity == Q_ODD) ? r_odd_head : r_even_head;
        w_tgt_cnt  = (r_parity == Q_ODD) ? r_odd_cnt  : r_even_cnt;
        w_tail_sum = SUM_W'(w_tgt_head) + SUM_W'(w_tgt_cnt);
        w_tail     = (w_tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     w_tail_sum - SUM_W'(QUEUE_DEPTH) : w_tail_sum;
        w_push_req = i_cmd.start && ((i_cmd.op == OP_ADD) || i_cmd.requeue);
        w_full     = w_push_req && (w_tgt_cnt == CNT_W'(QUEUE_DEPTH));
        w_push_en  = w_push_req && !w_full;
    end

    // pop picks the even queue first, counting this request's push
    always_comb begin
        w_even_cnt_p = r_even_cnt + CNT_W'(w_push_en && (r_parity == Q_EVEN));
        w_odd_cnt_p  = r_odd_cnt  + CNT_W'(w_push_en && (r_parity == Q_ODD));
        w_pop_en     = 1'b0;
        w_pop_q      = Q_EVEN;
        if (i_cmd.start && (i_cmd.op == OP_GET)) begin
            priority if (w_even_cnt_p != '0) begin
                w_pop_en = 1'b1;
                w_pop_q  = Q_EVEN;
            end else if (w_odd_cnt_p != '0) begin
                w_pop_en = 1'b1;
                w_pop_q  = Q_ODD;
            end
        end
        w_pop_even = w_pop_en && (w_pop_q == Q_EVEN);
        w_pop_odd  = w_pop_en && (w_pop_q == Q_ODD);
        w_pop_head = (w_pop_q == Q_ODD) ? r_odd_head : r_even_head;
        // the popped queue was empty before the push: its head is the new entry
        w_fwd = w_pop_en && w_push_en && (w_pop_q == r_parity) && (w_tgt_cnt == '0);
    end

    // next pointer state
    always_comb begin
        n_even_cnt  = w_even_cnt_p - CNT_W'(w_pop_even);
        n_odd_cnt   = w_odd_cnt_p  - CNT_W'(w_pop_odd);
        n_even_head = r_even_head;
        n_odd_head  = r_odd_head;
        if (w_pop_even) begin
            n_even_head = (r_even_head == SLOT_W'(QUEUE_DEPTH - 1)) ?
                          '0 : r_even_head + SLOT_W'(1);
        end
        if (w_pop_odd) begin
            n_odd_head = (r_odd_head == SLOT_W'(QUEUE_DEPTH - 1)) ?
                         '0 : r_odd_head + SLOT_W'(1);
        end
        n_parity = r_parity ^ w_push_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_head <= '0;
            r_odd_head  <= '0;
            r_even_cnt  <= '0;
            r_odd_cnt   <= '0;
            r_parity    <= Q_EVEN;
        end else begin
            r_even_head <= n_even_head;
            r_odd_head  <= n_odd_head;
            r_even_cnt  <= n_even_cnt;
            r_odd_cnt   <= n_odd_cnt;
            r_parity    <= n_parity;
        end
    end

    assign o_plan.push_en = w_push_en;
    assign o_plan.push_q  = r_parity;
    assign o_plan.full    = w_full;
    assign o_plan.pop_en  = w_pop_en;
    assign o_plan.pop_q   = w_pop_q;
    assign o_plan.fwd     = w_fwd;
    assign o_push_slot    = w_tail[SLOT_W-1:0];
    assign o_pop_slot     = w_pop_head;

    // fill counts never pass the queue depth
    a_even_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_even_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("even queue count above depth");
    a_odd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_odd_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("odd queue count above depth");
    // parity flips exactly after a push that went in
    a_parity_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_parity != $past(r_parity)) == $past(w_push_en)))
        else $error("arrival parity out of step with pushes");

endmodule

// ----- rtl/odd_even_two_queue_scheduler.sv -----
`timescale 1ns / 1ps
// Odd/even two-queue task scheduler, top level.
// Depends on oeq_pkg, oeq_if, oeq_mem and oeq_ptrs.
//
// Usage:
//   i_req carries one request: op (add or get-next), task_id for an add, and
//   running_has_time for a get-next. o_rsp returns exactly one result per
//   request: next_task/next_valid for a get-next, full_error when an add or
//   a requeue of the running task hit a full queue.
//   Both queues share one memory with one write and one read port. A request
//   is accepted on a valid/ready edge; the push is written and the pop head
//   read at that same edge, and the result is registered at the next edge,
//   when o_rsp.valid rises. No new request is taken while one is in
//   ST_RESP, since the registered read of the queue memory must land
//   before the result can be formed.
//   A get-next that pops the entry it just requeued into an empty queue
//   takes the id from a bypass register instead of the memory.
//   Reset (i_rst_n low, synchronous) empties both queues, clears the parity
//   and the running task; memory contents are left as they are.
//   While o_rsp is stalled, the held result stays put and no new request is
//   taken until the result is taken.
module odd_even_two_queue_scheduler
    import oeq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    oeq_req_if.sink        i_req,
    oeq_rsp_if.source      o_rsp
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = SLOT_W + 1;
    localparam int WIDE_W = (TASK_ID_BITS > ID_FIELD_W) ? TASK_ID_BITS : ID_FIELD_W;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } t_state;

    t_state                  r_state;
    logic                    r_op;
    logic                    r_full;
    logic                    r_pop_en;
    logic                    r_fwd;
    logic [TASK_ID_BITS-1:0] r_fwd_id;
    logic                    r_run_valid;
    logic [TASK_ID_BITS-1:0] r_run_id;
    logic                    r_out_valid;
    logic [ID_FIELD_W-1:0]   r_out_task;
    logic                    r_out_nvalid;
    logic                    r_out_full;

    logic                    w_ready;
    logic                    w_accept;
    logic                    w_out_take;
    t_cmd                    w_cmd;
    t_plan                   w_plan;
    logic [SLOT_W-1:0]       w_push_slot;
    logic [SLOT_W-1:0]       w_pop_slot;
    logic [WIDE_W-1:0]       w_in_wide;
    logic [TASK_ID_BITS-1:0] w_push_id;
    logic [TASK_ID_BITS-1:0] w_rd_id;
    logic [TASK_ID_BITS-1:0] w_pop_id;
    logic [WIDE_W-1:0]       w_pop_wide;

    // request handshake
    assign w_ready    = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept   = i_req.valid && w_ready;
    assign w_out_take = r_out_valid && o_rsp.ready;
    assign i_req.ready = w_ready;

    assign w_cmd.start   = w_accept;
    assign w_cmd.op      = i_req.op;
    assign w_cmd.requeue = r_run_valid && i_req.running_has_time;

    oeq_ptrs #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ptrs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_plan      (w_plan),
        .o_push_slot (w_push_slot),
        .o_pop_slot  (w_pop_slot)
    );

    // pushed id: the new task for an add, the running task for a requeue
    assign w_in_wide = WIDE_W'(i_req.task_id);
    assign w_push_id = (i_req.op == OP_ADD) ? w_in_wide[TASK_ID_BITS-1:0] : r_run_id;

    oeq_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (TASK_ID_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_plan.push_en),
        .i_waddr ({w_plan.push_q, w_push_slot}),
        .i_wdata (w_push_id),
        .i_re    (w_plan.pop_en),
        .i_raddr ({w_plan.pop_q, w_pop_slot}),
        .o_rdata (w_rd_id)
    );

    // popped id, with bypass of a same-cycle push into an empty queue
    assign w_pop_id   = r_fwd ? r_fwd_id : w_rd_id;
    assign w_pop_wide = WIDE_W'(w_pop_id);

    // control, running task and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_out_valid <= 1'b0;
            r_pop_en    <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_out_take) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_accept) begin
                        r_state  <= ST_RESP;
                        r_op     <= i_req.op;
                        r_full   <= w_plan.full;
                        r_pop_en <= w_plan.pop_en;
                        r_fwd    <= w_plan.fwd;
                        r_fwd_id <= w_push_id;
                    end
                end
                ST_RESP: begin
                    r_state      <= ST_IDLE;
                    r_out_valid  <= 1'b1;
                    r_out_full   <= r_full;
                    r_out_nvalid <= r_pop_en;
                    r_out_task   <= r_pop_en ? w_pop_wide[ID_FIELD_W-1:0] : '0;
                    if (r_pop_en) begin
                        r_run_valid <= 1'b1;
                        r_run_id    <= w_pop_id;
                    end else if (r_op == OP_GET) begin
                        r_run_valid <= 1'b0;
                        r_run_id    <= '0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.next_task  = r_out_task;
    assign o_rsp.next_valid = r_out_nvalid;
    assign o_rsp.full_error = r_out_full;

    // every accepted request yields a result once its ST_RESP state has passed
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_rsp.valid)
        else $error("result missing after request");
    // the bypass only serves a pop
    a_fwd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) && r_fwd |-> r_pop_en)
        else $error("bypass without pop");
    // a result with a selected task leaves that task running
    a_run_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) && r_pop_en |=> r_run_valid && o_rsp.next_valid)
        else $error("popped task not marked running");
    // a result never lands on a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> !r_out_valid)
        else $error("result register overwritten");

endmodule

// ----- verif/odd_even_two_queue_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the odd/even two-queue task scheduler.
// Depends on oeq_pkg, oeq_if and the RTL under rtl/.
module odd_even_two_queue_scheduler_tb;
    import oeq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // one result as it appears on the result channel
    typedef struct packed {
        logic [ID_FIELD_W-1:0] next_task;
        logic                  next_valid;
        logic                  full_error;
    } t_sched_pick;

    // Keeps a copy of both task queues, the parity and the running task,
    // and checks every result against the pick predicted for its request.
    class pick_scoreboard;
        int unsigned           queue_depth;
        logic [ID_FIELD_W-1:0] id_mask;
        logic [ID_FIELD_W-1:0] even_tasks[$];
        logic [ID_FIELD_W-1:0] odd_tasks[$];
        logic                  parity;
        logic [ID_FIELD_W-1:0] running_id;
        logic                  running_valid;
        t_sched_pick           expected_picks[$];
        int unsigned           mismatches;

        function new(int unsigned depth, int unsigned id_bits);
            queue_depth   = depth;
            id_mask       = ID_FIELD_W'((1 << id_bits) - 1);
            parity        = Q_EVEN;
            running_id    = '0;
            running_valid = 1'b0;
            mismatches    = 0;
        endfunction

        // returns 1 when the target queue is full and the id is dropped
        function bit push_by_parity(logic [ID_FIELD_W-1:0] id);
            if (parity == Q_ODD) begin
                if (odd_tasks.size() >= queue_depth) return 1'b1;
                odd_tasks.push_back(id & id_mask);
            end else begin
                if (even_tasks.size() >= queue_depth) return 1'b1;
                even_tasks.push_back(id & id_mask);
            end
            parity = ~parity;
            return 1'b0;
        endfunction

        function void note_request(logic op, logic [ID_FIELD_W-1:0] id, logic has_time);
            t_sched_pick pick;
            pick = '0;
            if (op == OP_ADD) begin
                pick.full_error = push_by_parity(id);
            end else begin
                // requeue the running task first, then pop even before odd
                if (running_valid && has_time)
                    pick.full_error = push_by_parity(running_id);
                running_valid = 1'b0;
                running_id    = '0;
                if (even_tasks.size() > 0) begin
                    running_id    = even_tasks.pop_front();
                    running_valid = 1'b1;
                end else if (odd_tasks.size() > 0) begin
                    running_id    = odd_tasks.pop_front();
                    running_valid = 1'b1;
                end
                pick.next_task  = running_id;
                pick.next_valid = running_valid;
            end
            expected_picks.push_back(pick);
        endfunction

        function void check_result(t_sched_pick got);
            t_sched_pick want;
            if (expected_picks.size() == 0) begin
                $display("%0t: result with no request pending: task=%h valid=%b full=%b",
                         $time, got.next_task, got.next_valid, got.full_error);
                mismatches++;
                return;
            end
            want = expected_picks.pop_front();
            if (got.next_task !== want.next_task) begin
                $display("%0t: next_task expected %h, got %h",
                         $time, want.next_task, got.next_task);
                mismatches++;
            end
            if (got.next_valid !== want.next_valid) begin
                $display("%0t: next_valid expected %b, got %b",
                         $time, want.next_valid, got.next_valid);
                mismatches++;
            end
            if (got.full_error !== want.full_error) begin
                $display("%0t: full_error expected %b, got %b",
                         $time, want.full_error, got.full_error);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    oeq_req_if req_ch ();
    oeq_rsp_if rsp_ch ();

    odd_even_two_queue_scheduler #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pick_scoreboard pick_board;
    int unsigned    tx_idle_pct  = 0;
    int unsigned    rx_stall_pct = 0;
    int unsigned    rx_hold_left = 0;
    int unsigned    requests_sent = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // both channels sampled at the edge, before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                pick_board.note_request(req_ch.op, req_ch.task_id, req_ch.running_has_time);
            if (rsp_ch.valid && rsp_ch.ready)
                pick_board.check_result({rsp_ch.next_task, rsp_ch.next_valid,
                                         rsp_ch.full_error});
        end
    end

    // watchdog: too long without any request or result moving
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** odd_even_two_queue_scheduler: FAILED **");
        $finish;
    end

    // offer one request until taken, then maybe go idle for a while
    task automatic send_request(input logic op, input logic [ID_FIELD_W-1:0] id,
                                input logic has_time);
        req_ch.valid            <= 1'b1;
        req_ch.op               <= op;
        req_ch.task_id          <= id;
        req_ch.running_has_time <= has_time;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop offering until every predicted result has come back
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pick_board.expected_picks.size() != 0) @(posedge i_clk);
    endtask

    // one random sequence: mixed traffic, a fill burst, or a drain run
    task automatic run_segment();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 50) begin
            repeat ($urandom_range(30, 10))
                send_request(($urandom_range(99) < 45) ? OP_GET : OP_ADD,
                             ID_FIELD_W'($urandom), 1'($urandom));
        end else if (kind < 75) begin
            // enough adds to fill both queues, then gets that try to requeue
            repeat ($urandom_range(38, 34))
                send_request(OP_ADD, ID_FIELD_W'($urandom), 1'($urandom));
            repeat ($urandom_range(5, 3))
                send_request(OP_GET, ID_FIELD_W'($urandom), 1'b1);
        end else begin
            repeat ($urandom_range(36, 20))
                send_request(OP_GET, ID_FIELD_W'($urandom), ($urandom_range(99) < 20));
        end
    endtask

    initial begin
        int unsigned phase_end;
        pick_board = new(QUEUE_DEPTH, TASK_ID_BITS);
        i_rst_n                 <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.op               <= OP_ADD;
        req_ch.task_id          <= '0;
        req_ch.running_has_time <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle gets, extreme ids, requeue, bypass of a fresh requeue
        send_request(OP_GET, 8'hFF, 1'b1);   // nothing running, time flag ignored
        send_request(OP_GET, 8'h00, 1'b0);
        send_request(OP_ADD, 8'h00, 1'b1);   // even
        send_request(OP_ADD, 8'hFF, 1'b0);   // odd
        send_request(OP_ADD, 8'hA5, 1'b0);   // even
        send_request(OP_GET, 8'h5A, 1'b0);   // pops 00
        send_request(OP_GET, 8'h00, 1'b1);   // requeue 00 to odd, pops A5
        send_request(OP_GET, 8'hFF, 1'b1);   // requeue A5 into empty even, pops it back
        send_request(OP_GET, 8'h00, 1'b1);   // requeue A5 to odd, pops FF from odd
        send_request(OP_GET, 8'h00, 1'b0);
        send_request(OP_GET, 8'h00, 1'b0);
        send_request(OP_GET, 8'h00, 1'b1);   // lone running task goes around again
        send_request(OP_GET, 8'h00, 1'b0);   // idle
        send_request(OP_GET, 8'h00, 1'b1);   // idle, nothing to requeue
        send_request(OP_ADD, 8'h5A, 1'b1);
        send_request(OP_ADD, 8'h3C, 1'b0);
        send_request(OP_GET, 8'hC3, 1'b1);
        send_request(OP_GET, 8'h81, 1'b1);
        send_request(OP_GET, 8'h7E, 1'b0);
        pause_until_drained();

        // random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    rx_hold_left = HOLD_CYCLES;   // block backs up, input stalls
                end
                1: begin
                    tx_idle_pct  = 61;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 61;
                end
                default: begin
                    tx_idle_pct  = 21;
                    rx_stall_pct = 21;
                end
            endcase
            phase_end = requests_sent + RANDOM_ITEMS / 4;
            while (requests_sent < phase_end) run_segment();
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pick_board.mismatches == 0 && pick_board.expected_picks.size() == 0)
            $display("** odd_even_two_queue_scheduler: PASSED **");
        else
            $display("** odd_even_two_queue_scheduler: FAILED **");
        $finish;
    end

endmodule
